@@ hw/rtl/rsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rounding signed divider package
// Sideband control that travels with each beat down the divider pipeline.
// ----------------------------------------------------------------------------
package rsd_pkg;

  typedef struct packed {
    logic valid;
    logic negative;
    logic zero_div;
  } rsd_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/rsd_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rounding signed divider: operand preparation
// Registers the dividend magnitude plus half the divisor, and the divisor.
// ----------------------------------------------------------------------------
module rsd_prep import rsd_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [W-1:0] dividend,
  input  wire logic        [W-2:0] divisor,
  output rsd_ctrl_t                ctrl,
  output logic             [W-1:0] num,
  output logic             [W-2:0] dvs
);

  logic         negative;
  logic [W-1:0] mag;
  logic [W-1:0] num_next;

  always_comb begin
    negative = dividend[W-1];
    mag      = negative ? (~dividend + W'(1)) : dividend;
    num_next = mag + W'(divisor >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= start;
    end
    ctrl.negative <= negative;
    ctrl.zero_div <= (divisor == '0);
    num           <= num_next;
    dvs           <= divisor;
  end

endmodule
`default_nettype wire

@@ hw/rtl/rsd_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rounding signed divider: restoring division stage
// Resolves one quotient bit per stage and registers the partial remainder.
// ----------------------------------------------------------------------------
module rsd_div_stage import rsd_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rsd_ctrl_t    ctrl_in,
  input  wire logic [W-2:0] rem_in,
  input  wire logic [W-1:0] work_in,
  input  wire logic [W-1:0] num_in,
  input  wire logic [W-2:0] dvs_in,
  output rsd_ctrl_t         ctrl_out,
  output logic      [W-2:0] rem_out,
  output logic      [W-1:0] work_out,
  output logic      [W-1:0] num_out,
  output logic      [W-2:0] dvs_out
);

  logic [W-1:0] trial;
  logic [W-1:0] diff;
  logic         ge;
  logic [W-2:0] rem_next;

  always_comb begin
    trial    = {rem_in, work_in[W-1]};
    diff     = trial - {1'b0, dvs_in};
    ge       = (trial >= {1'b0, dvs_in});
    rem_next = ge ? diff[W-2:0] : trial[W-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.negative <= ctrl_in.negative;
    ctrl_out.zero_div <= ctrl_in.zero_div;
    rem_out           <= rem_next;
    work_out          <= {work_in[W-2:0], ge};
    num_out           <= num_in;
    dvs_out           <= dvs_in;
  end

endmodule
`default_nettype wire

@@ hw/rtl/rsd_finish.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rounding signed divider: result stage
// Forms the nearest multiple from the remainder and applies the sign, or clears both results on a divide by zero.
// ----------------------------------------------------------------------------
module rsd_finish import rsd_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rsd_ctrl_t    ctrl_in,
  input  wire logic [W-2:0] rem_in,
  input  wire logic [W-1:0] quo_in,
  input  wire logic [W-1:0] num_in,
  output logic              done,
  output logic signed [W-1:0] quotient,
  output logic signed [W:0]   nearest_multiple,
  output logic              divide_by_zero
);

  logic [W-1:0] mult_mag;
  logic [W-1:0] quo_next;
  logic [W:0]   mult_next;

  always_comb begin
    mult_mag = num_in - {1'b0, rem_in};
    if (ctrl_in.zero_div) begin
      quo_next  = '0;
      mult_next = '0;
    end else if (ctrl_in.negative) begin
      quo_next  = ~quo_in + W'(1);
      mult_next = ~{1'b0, mult_mag} + (W+1)'(1);
    end else begin
      quo_next  = quo_in;
      mult_next = {1'b0, mult_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_in.valid;
    end
    quotient         <= quo_next;
    nearest_multiple <= mult_next;
    divide_by_zero   <= ctrl_in.zero_div;
  end

endmodule
`default_nettype wire

@@ hw/rtl/rounding_signed_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rounding signed divider
// Signed division with halves rounded away from zero, plus the nearest
// multiple of the divisor.
// ----------------------------------------------------------------------------
// The block takes one beat in every clock cycle and never raises busy. Each
// result passes through these registers in order before it appears on done:
// rsd_prep forms the magnitude plus half the divisor, DATA_WIDTH restoring
// division stages resolve one quotient bit each, and rsd_finish applies the
// sign. The receiver must take every result in the cycle that done is high.
// ----------------------------------------------------------------------------
module rounding_signed_divider import rsd_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] dividend,
  input  wire logic        [DATA_WIDTH-2:0] divisor,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      quotient,
  output logic signed [DATA_WIDTH:0]        nearest_multiple,
  output logic                              divide_by_zero
);

  localparam int W       = DATA_WIDTH;
  localparam int LATENCY = DATA_WIDTH + 2;

  rsd_ctrl_t    ctrl [W+1];
  logic [W-2:0] rem  [W+1];
  logic [W-1:0] work [W+1];
  logic [W-1:0] num  [W+1];
  logic [W-2:0] dvs  [W+1];
  logic [W-1:0] prep_num;

  assign busy    = 1'b0;
  assign rem[0]  = '0;
  assign work[0] = prep_num;
  assign num[0]  = prep_num;

  rsd_prep #(.W(W)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (dividend),
    .divisor  (divisor),
    .ctrl     (ctrl[0]),
    .num      (prep_num),
    .dvs      (dvs[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_stage
    rsd_div_stage #(.W(W)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .ctrl_in  (ctrl[i]),
      .rem_in   (rem[i]),
      .work_in  (work[i]),
      .num_in   (num[i]),
      .dvs_in   (dvs[i]),
      .ctrl_out (ctrl[i+1]),
      .rem_out  (rem[i+1]),
      .work_out (work[i+1]),
      .num_out  (num[i+1]),
      .dvs_out  (dvs[i+1])
    );
  end

  rsd_finish #(.W(W)) u_finish (
    .clk              (clk),
    .rst              (rst),
    .ctrl_in          (ctrl[W]),
    .rem_in           (rem[W]),
    .quo_in           (work[W]),
    .num_in           (num[W]),
    .done             (done),
    .quotient         (quotient),
    .nearest_multiple (nearest_multiple),
    .divide_by_zero   (divide_by_zero)
  );

`ifndef SYNTHESIS
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result beat without a matching start beat");

  a_zero_div_clears: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (quotient == '0 && nearest_multiple == '0))
    else $error("divide by zero result not cleared");

  a_sign_match: assert property (@(posedge clk) disable iff (rst)
    (done && !divide_by_zero) |-> (nearest_multiple[W] == quotient[W-1]))
    else $error("nearest multiple sign disagrees with quotient sign");
`endif

endmodule
`default_nettype wire
